// File: rtl/triangle_metrics_unit_macros.svh
// Assertion macros shared by the checkers of the triangle metrics unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TRIANGLE_METRICS_UNIT_MACROS_SVH
`define TRIANGLE_METRICS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tmu_pkg.sv
`default_nettype none

package tmu_pkg;

    // Field widths of the ports.
    localparam int COORD_W = 24;
    localparam int SQ_W    = 50;
    localparam int LEN_W   = 25;
    localparam int PERIM_W = 27;
    localparam int AREA_W  = 49;
    localparam int COS_W   = 32;

    // Internal widths.
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CSQ_W    = 2 * COORD_W + 1;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int NMAG_W   = PROD_W;
    localparam int HALF_W   = NMAG_W / 2;
    localparam int RAD_W    = 2 * NMAG_W;
    localparam int AROOT_W  = RAD_W / 2;
    localparam int LREM_W   = LEN_W + 3;
    localparam int AREM_W   = AROOT_W + 3;
    localparam int COS_FRAC = 30;
    localparam int QUO_W    = COS_FRAC + 1;
    localparam int NUM_W    = SQ_W + 1;
    localparam int DIV_W    = NUM_W + 1;

    // Cosine of plus one in Q2.30.
    localparam logic signed [COS_W-1:0] COS_LIMIT = COS_W'(64'd1 << COS_FRAC);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } edge_t;

    // Edge vectors of one triangle: c-b, a-c and b-a.
    typedef struct packed {
        edge_t bc;
        edge_t ca;
        edge_t ab;
    } edges_t;

endpackage

`default_nettype wire

// File: rtl/tmu_front.sv
`default_nettype none

module tmu_front
    import tmu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [COORD_W-1:0] point_a_x,
    input  logic signed [COORD_W-1:0] point_a_y,
    input  logic signed [COORD_W-1:0] point_a_z,
    input  logic signed [COORD_W-1:0] point_b_x,
    input  logic signed [COORD_W-1:0] point_b_y,
    input  logic signed [COORD_W-1:0] point_b_z,
    input  logic signed [COORD_W-1:0] point_c_x,
    input  logic signed [COORD_W-1:0] point_c_y,
    input  logic signed [COORD_W-1:0] point_c_z,
    output logic                      word_valid,
    output edges_t                    word,
    input  logic                      queue_full
);

    logic   vld_reg;
    edges_t word_reg;
    edges_t word_next;

    // The held word leaves as soon as the queue has room.
    assign word_valid = vld_reg;
    assign word       = word_reg;
    assign item_ready = !vld_reg || !queue_full;

    // Edge vectors, one bit wider than the coordinates.
    always_comb
    begin
        word_next.bc.x = DIFF_W'(point_c_x) - DIFF_W'(point_b_x);
        word_next.bc.y = DIFF_W'(point_c_y) - DIFF_W'(point_b_y);
        word_next.bc.z = DIFF_W'(point_c_z) - DIFF_W'(point_b_z);
        word_next.ca.x = DIFF_W'(point_a_x) - DIFF_W'(point_c_x);
        word_next.ca.y = DIFF_W'(point_a_y) - DIFF_W'(point_c_y);
        word_next.ca.z = DIFF_W'(point_a_z) - DIFF_W'(point_c_z);
        word_next.ab.x = DIFF_W'(point_b_x) - DIFF_W'(point_a_x);
        word_next.ab.y = DIFF_W'(point_b_y) - DIFF_W'(point_a_y);
        word_next.ab.z = DIFF_W'(point_b_z) - DIFF_W'(point_a_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tmu_queue.sv
`default_nettype none

module tmu_queue
    import tmu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  edges_t push_word,
    output logic   full,
    input  logic   pop,
    output edges_t pop_word,
    output logic   not_empty
);

    edges_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic                pop_ok;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_ok    = pop && not_empty;
    assign pop_word  = mem_reg[rd_reg];

    // Occupancy follows pushes and pops; the writer never pushes when full.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop_ok)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (!push && pop_ok)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tmu_back.sv
`default_nettype none

module tmu_back
    import tmu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    word_valid,
    input  edges_t                  word,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [SQ_W-1:0]         sq_len_bc,
    output logic [SQ_W-1:0]         sq_len_ca,
    output logic [SQ_W-1:0]         sq_len_ab,
    output logic [LEN_W-1:0]        len_bc,
    output logic [LEN_W-1:0]        len_ca,
    output logic [LEN_W-1:0]        len_ab,
    output logic [PERIM_W-1:0]      perimeter,
    output logic [AREA_W-1:0]       area,
    output logic signed [COS_W-1:0] cos_max_angle,
    output logic                    degenerate
);

    // Stage numbers of the pipeline.
    localparam int S_PROD = 1;
    localparam int S_SUM  = 2;
    localparam int S_LSQ0 = 3;
    localparam int S_LSQN = S_LSQ0 + LEN_W - 1;
    localparam int S_LEN  = S_LSQN + 1;
    localparam int S_POS  = S_LEN + 1;
    localparam int S_NUM  = S_POS + 1;
    localparam int S_DIV0 = S_NUM + 1;
    localparam int S_DIVN = S_DIV0 + COS_FRAC - 1;
    localparam int S_COS  = S_DIVN + 1;
    localparam int S_OUT  = S_COS + 1;
    localparam int S_AMAG = 3;
    localparam int S_APP  = 4;
    localparam int S_ASQR = 5;
    localparam int S_ARAD = 6;
    localparam int S_ASQ0 = 7;
    localparam int S_ASQN = S_ASQ0 + AROOT_W - 1;
    localparam int S_AREA = S_ASQN + 1;

    localparam logic [QUO_W-1:0] COS_ONE = QUO_W'(1) << COS_FRAC;

    typedef logic [2:0][SQ_W-1:0]  sq3_t;
    typedef logic [2:0][LEN_W-1:0] len3_t;

    logic                      en;
    logic [S_OUT:S_PROD]       vld_reg;
    edge_t                     edge_in [3];

    logic [CSQ_W-1:0]          csq_reg [3][3];
    logic signed [PROD_W-1:0]  xp_reg [3][2];
    sq3_t                      sq_reg [S_SUM:S_OUT];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [NMAG_W-1:0]         nm_reg [3];
    logic [PROD_W-1:0]         pp_reg [3][3];
    logic [RAD_W-1:0]          nsq_reg [3];
    logic [RAD_W-1:0]          rad_reg [S_ARAD:S_ASQN-1];
    logic [AREM_W-1:0]         arem_reg [S_ASQ0:S_ASQN-1];
    logic [AROOT_W-1:0]        aroot_reg [S_ASQ0:S_ASQN];
    logic [AREA_W-1:0]         area_reg [S_AREA:S_OUT];

    logic [LREM_W-1:0]         lrem_reg [3][S_LSQ0:S_LSQN-1];
    logic [LEN_W-1:0]          lroot_reg [3][S_LSQ0:S_LSQN];
    len3_t                     len_reg [S_LEN:S_OUT];
    logic [PERIM_W-1:0]        perim_reg [S_LEN:S_OUT];
    logic [S_OUT:S_LEN]        degen_reg;

    logic [SQ_W-1:0]           lsq_reg [3];
    logic [SQ_W-1:0]           lpr_reg [3];
    logic [NUM_W-1:0]          pos_reg [3];
    logic [NUM_W-1:0]          negsq_reg [3];
    logic [NUM_W-1:0]          den_reg [3];
    logic [DIV_W-1:0]          dnum_reg [3][S_NUM:S_DIVN-1];
    logic [NUM_W-1:0]          dden_reg [3][S_NUM:S_DIVN-1];
    logic                      dsg_reg [3][S_NUM:S_DIVN];
    logic                      dsat_reg [3][S_NUM:S_DIVN];
    logic [QUO_W-1:0]          dq_reg [3][S_DIV0:S_DIVN];
    logic signed [COS_W-1:0]   cval_reg [3];
    logic signed [COS_W-1:0]   cos_reg;

    function automatic logic signed [PROD_W-1:0] mul_s(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic [CSQ_W-1:0] comp_sq(input logic signed [DIFF_W-1:0] a);
        logic signed [PROD_W-1:0] p;
        p = mul_s(a, a);
        return p[CSQ_W-1:0];
    endfunction

    function automatic logic [NMAG_W-1:0] mag_n(input logic signed [CROSS_W-1:0] n);
        logic signed [CROSS_W-1:0] t;
        t = n[CROSS_W-1] ? -n : n;
        return t[NMAG_W-1:0];
    endfunction

    // The whole pipeline moves unless a finished word waits at the output.
    assign en           = !vld_reg[S_OUT] || result_ready;
    assign pop          = en;
    assign result_valid = vld_reg[S_OUT];

    assign edge_in[0] = word.bc;
    assign edge_in[1] = word.ca;
    assign edge_in[2] = word.ab;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[S_OUT-1:S_PROD], word_valid};
        end
    end

    // Component squares and the cross product terms of (c-b) x (b-a).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 3; e++)
            begin
                csq_reg[e][0] <= comp_sq(edge_in[e].x);
                csq_reg[e][1] <= comp_sq(edge_in[e].y);
                csq_reg[e][2] <= comp_sq(edge_in[e].z);
            end
            xp_reg[0][0] <= mul_s(word.bc.y, word.ab.z);
            xp_reg[0][1] <= mul_s(word.bc.z, word.ab.y);
            xp_reg[1][0] <= mul_s(word.bc.z, word.ab.x);
            xp_reg[1][1] <= mul_s(word.bc.x, word.ab.z);
            xp_reg[2][0] <= mul_s(word.bc.x, word.ab.y);
            xp_reg[2][1] <= mul_s(word.bc.y, word.ab.x);
        end
    end

    // Squared edge lengths, carried to the output.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 3; e++)
            begin
                sq_reg[S_SUM][e] <= SQ_W'(csq_reg[e][0]) + SQ_W'(csq_reg[e][1])
                                    + SQ_W'(csq_reg[e][2]);
            end
            for (int k = S_SUM + 1; k <= S_OUT; k++)
            begin
                sq_reg[k] <= sq_reg[k-1];
            end
        end
    end

    // Normal vector, its magnitude, its square by partial products and the sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]     <= CROSS_W'(xp_reg[i][0]) - CROSS_W'(xp_reg[i][1]);
                nm_reg[i]    <= mag_n(n_reg[i]);
                pp_reg[i][0] <= PROD_W'(nm_reg[i][NMAG_W-1:HALF_W])
                                * PROD_W'(nm_reg[i][NMAG_W-1:HALF_W]);
                pp_reg[i][1] <= PROD_W'(nm_reg[i][NMAG_W-1:HALF_W])
                                * PROD_W'(nm_reg[i][HALF_W-1:0]);
                pp_reg[i][2] <= PROD_W'(nm_reg[i][HALF_W-1:0])
                                * PROD_W'(nm_reg[i][HALF_W-1:0]);
                nsq_reg[i]   <= (RAD_W'(pp_reg[i][0]) << (2 * HALF_W))
                                + (RAD_W'(pp_reg[i][1]) << (HALF_W + 1))
                                + RAD_W'(pp_reg[i][2]);
            end
            rad_reg[S_ARAD] <= nsq_reg[0] + nsq_reg[1] + nsq_reg[2];
        end
    end

    // Area square root, one result bit per stage.
    for (genvar j = 0; j < AROOT_W; j++)
    begin : g_asq
        localparam int K = S_ASQ0 + j;
        logic [AREM_W-1:0]  rem_prev;
        logic [AROOT_W-1:0] root_prev;
        logic [AREM_W-1:0]  rt;
        logic [AREM_W-1:0]  trial;
        logic               ge;

        if (j == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev  = arem_reg[K-1];
            assign root_prev = aroot_reg[K-1];
        end

        always_comb
        begin
            rt    = {rem_prev[AREM_W-3:0], rad_reg[K-1][RAD_W-1-2*j -: 2]};
            trial = {1'b0, root_prev, 2'b01};
            ge    = (rt >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                aroot_reg[K] <= {root_prev[AROOT_W-2:0], ge};
            end
        end

        if (j < AROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    arem_reg[K] <= ge ? (rt - trial) : rt;
                    rad_reg[K]  <= rad_reg[K-1];
                end
            end
        end
    end

    // Area is half the root, carried to the output.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            area_reg[S_AREA] <= aroot_reg[S_ASQN][AROOT_W-1:1];
            for (int k = S_AREA + 1; k <= S_OUT; k++)
            begin
                area_reg[k] <= area_reg[k-1];
            end
        end
    end

    // Edge length square roots, one result bit per stage for each edge.
    for (genvar e = 0; e < 3; e++)
    begin : g_edge
        for (genvar j = 0; j < LEN_W; j++)
        begin : g_lsq
            localparam int K = S_LSQ0 + j;
            logic [LREM_W-1:0] rem_prev;
            logic [LEN_W-1:0]  root_prev;
            logic [LREM_W-1:0] rt;
            logic [LREM_W-1:0] trial;
            logic              ge;

            if (j == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
            end
            else
            begin : g_rest
                assign rem_prev  = lrem_reg[e][K-1];
                assign root_prev = lroot_reg[e][K-1];
            end

            always_comb
            begin
                rt    = {rem_prev[LREM_W-3:0], sq_reg[K-1][e][SQ_W-1-2*j -: 2]};
                trial = {1'b0, root_prev, 2'b01};
                ge    = (rt >= trial);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lroot_reg[e][K] <= {root_prev[LEN_W-2:0], ge};
                end
            end

            if (j < LEN_W - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        lrem_reg[e][K] <= ge ? (rt - trial) : rt;
                    end
                end
            end
        end
    end

    // Lengths, perimeter and the zero-length flag, carried to the output.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 3; e++)
            begin
                len_reg[S_LEN][e] <= lroot_reg[e][S_LSQN];
            end
            perim_reg[S_LEN] <= PERIM_W'(lroot_reg[0][S_LSQN])
                                + PERIM_W'(lroot_reg[1][S_LSQN])
                                + PERIM_W'(lroot_reg[2][S_LSQN]);
            degen_reg[S_LEN] <= (lroot_reg[0][S_LSQN] == '0)
                                || (lroot_reg[1][S_LSQN] == '0)
                                || (lroot_reg[2][S_LSQN] == '0);
            for (int k = S_LEN + 1; k <= S_OUT; k++)
            begin
                len_reg[k]   <= len_reg[k-1];
                perim_reg[k] <= perim_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    // Cosine at each corner: the opposite edge is e, the adjacent ones e1 and e2.
    for (genvar e = 0; e < 3; e++)
    begin : g_corner
        localparam int E1 = (e + 1) % 3;
        localparam int E2 = (e + 2) % 3;
        logic             sg;
        logic [NUM_W-1:0] num;
        logic             sat;
        logic [QUO_W-1:0] qv;
        logic signed [COS_W-1:0] cpos;

        always_comb
        begin
            sg   = (negsq_reg[e] > pos_reg[e]);
            num  = sg ? (negsq_reg[e] - pos_reg[e]) : (pos_reg[e] - negsq_reg[e]);
            sat  = (num >= den_reg[e]);
            qv   = dsat_reg[e][S_DIVN] ? COS_ONE : dq_reg[e][S_DIVN];
            cpos = COS_W'(qv);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lsq_reg[e] <= SQ_W'(lroot_reg[e][S_LSQN]) * SQ_W'(lroot_reg[e][S_LSQN]);
                lpr_reg[e] <= SQ_W'(lroot_reg[E1][S_LSQN]) * SQ_W'(lroot_reg[E2][S_LSQN]);
                pos_reg[e]   <= NUM_W'(lsq_reg[E1]) + NUM_W'(lsq_reg[E2]);
                negsq_reg[e] <= NUM_W'(lsq_reg[e]);
                den_reg[e]   <= {lpr_reg[e], 1'b0};
                dnum_reg[e][S_NUM] <= DIV_W'(num);
                dden_reg[e][S_NUM] <= den_reg[e];
                dsg_reg[e][S_NUM]  <= sg;
                dsat_reg[e][S_NUM] <= sat;
                cval_reg[e] <= dsg_reg[e][S_DIVN] ? -cpos : cpos;
            end
        end

        // Restoring division, one quotient bit per stage.
        for (genvar j = 0; j < COS_FRAC; j++)
        begin : g_div
            localparam int K = S_DIV0 + j;
            logic [QUO_W-1:0] q_prev;
            logic [DIV_W-1:0] t;
            logic [DIV_W-1:0] dv;
            logic             ge;

            if (j == 0)
            begin : g_first
                assign q_prev = '0;
            end
            else
            begin : g_rest
                assign q_prev = dq_reg[e][K-1];
            end

            always_comb
            begin
                t  = {dnum_reg[e][K-1][DIV_W-2:0], 1'b0};
                dv = DIV_W'(dden_reg[e][K-1]);
                ge = (t >= dv);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dq_reg[e][K]   <= {q_prev[QUO_W-2:0], ge};
                    dsg_reg[e][K]  <= dsg_reg[e][K-1];
                    dsat_reg[e][K] <= dsat_reg[e][K-1];
                end
            end

            if (j < COS_FRAC - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        dnum_reg[e][K] <= ge ? (t - dv) : t;
                        dden_reg[e][K] <= dden_reg[e][K-1];
                    end
                end
            end
        end
    end

    // Smallest corner cosine; a zero-length edge forces zero.
    always_ff @(posedge clk)
    begin
        logic signed [COS_W-1:0] m01;
        logic signed [COS_W-1:0] m012;
        if (en)
        begin
            m01  = (cval_reg[1] < cval_reg[0]) ? cval_reg[1] : cval_reg[0];
            m012 = (cval_reg[2] < m01) ? cval_reg[2] : m01;
            cos_reg <= degen_reg[S_COS] ? '0 : m012;
        end
    end

    assign sq_len_bc     = sq_reg[S_OUT][0];
    assign sq_len_ca     = sq_reg[S_OUT][1];
    assign sq_len_ab     = sq_reg[S_OUT][2];
    assign len_bc        = len_reg[S_OUT][0];
    assign len_ca        = len_reg[S_OUT][1];
    assign len_ab        = len_reg[S_OUT][2];
    assign perimeter     = perim_reg[S_OUT];
    assign area          = area_reg[S_OUT];
    assign cos_max_angle = cos_reg;
    assign degenerate    = degen_reg[S_OUT];

endmodule

`default_nettype wire

// File: rtl/triangle_metrics_unit.sv
// Throughput: one triangle per cycle while the output is not stalled; the
// length, division and area root pipelines each retire one bit per stage,
// so no unit is shared between words. Reset clears only the valid flags,
// the queue pointers and the queue count; the datapath registers hold
// whatever they last captured.
`default_nettype none

module triangle_metrics_unit
    import tmu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [COORD_W-1:0] point_a_x,
    input  logic signed [COORD_W-1:0] point_a_y,
    input  logic signed [COORD_W-1:0] point_a_z,
    input  logic signed [COORD_W-1:0] point_b_x,
    input  logic signed [COORD_W-1:0] point_b_y,
    input  logic signed [COORD_W-1:0] point_b_z,
    input  logic signed [COORD_W-1:0] point_c_x,
    input  logic signed [COORD_W-1:0] point_c_y,
    input  logic signed [COORD_W-1:0] point_c_z,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [SQ_W-1:0]           sq_len_bc,
    output logic [SQ_W-1:0]           sq_len_ca,
    output logic [SQ_W-1:0]           sq_len_ab,
    output logic [LEN_W-1:0]          len_bc,
    output logic [LEN_W-1:0]          len_ca,
    output logic [LEN_W-1:0]          len_ab,
    output logic [PERIM_W-1:0]        perimeter,
    output logic [AREA_W-1:0]         area,
    output logic signed [COS_W-1:0]   cos_max_angle,
    output logic                      degenerate
);

    logic   f_valid;
    edges_t f_word;
    logic   q_full;
    logic   q_valid;
    edges_t q_word;
    logic   q_pop;

    // Front: takes the vertices and forms the edge vectors.
    tmu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .point_a_x  (point_a_x),
        .point_a_y  (point_a_y),
        .point_a_z  (point_a_z),
        .point_b_x  (point_b_x),
        .point_b_y  (point_b_y),
        .point_b_z  (point_b_z),
        .point_c_x  (point_c_x),
        .point_c_y  (point_c_y),
        .point_c_z  (point_c_z),
        .word_valid (f_valid),
        .word       (f_word),
        .queue_full (q_full)
    );

    // Queue that lets the front and the back stall on their own.
    tmu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && !q_full),
        .push_word (f_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (q_word),
        .not_empty (q_valid)
    );

    // Back: lengths, area and cosine pipeline.
    tmu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (q_valid),
        .word          (q_word),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .sq_len_bc     (sq_len_bc),
        .sq_len_ca     (sq_len_ca),
        .sq_len_ab     (sq_len_ab),
        .len_bc        (len_bc),
        .len_ca        (len_ca),
        .len_ab        (len_ab),
        .perimeter     (perimeter),
        .area          (area),
        .cos_max_angle (cos_max_angle),
        .degenerate    (degenerate)
    );

endmodule

`default_nettype wire

// File: rtl/tmu_checker.sv
`default_nettype none
`include "triangle_metrics_unit_macros.svh"

module tmu_checker
    import tmu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [LEN_W-1:0]        len_bc,
    input logic [LEN_W-1:0]        len_ca,
    input logic [LEN_W-1:0]        len_ab,
    input logic [PERIM_W-1:0]      perimeter,
    input logic [AREA_W-1:0]       area,
    input logic signed [COS_W-1:0] cos_max_angle,
    input logic                    degenerate
);

    // A degenerate word has a zero edge and a zero cosine.
    `TMU_ASSERT_NOW(a_degen_cos, result_valid && degenerate, cos_max_angle == '0 && (len_bc == '0 || len_ca == '0 || len_ab == '0), "degenerate word with bad cosine or lengths")

    // The cosine never leaves the range from minus one to plus one.
    `TMU_ASSERT_NOW(a_cos_range, result_valid && !degenerate, cos_max_angle <= COS_LIMIT && cos_max_angle >= -COS_LIMIT, "cosine outside plus or minus one")

    // The perimeter matches the lengths of the same word.
    `TMU_ASSERT_NOW(a_perimeter, result_valid, perimeter == PERIM_W'(len_bc) + PERIM_W'(len_ca) + PERIM_W'(len_ab), "perimeter does not match lengths")

    // A stalled result word stays valid and holds its area and cosine.
    `TMU_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(area) && $stable(cos_max_angle), "stalled result word changed")

endmodule

bind triangle_metrics_unit tmu_checker u_tmu_checker (.*);

`default_nettype wire
